// ===== rtl/msp_pkg.sv =====
package msp_pkg;

   localparam int SYSEX_DEPTH_MAX = 64;
   localparam int SYSEX_DEPTH_DEF = 64;
   localparam int CNT_W = $clog2(SYSEX_DEPTH_MAX + 1);
   localparam int TIME_W = 40;
   localparam int CMD_FIFO_DEPTH = 4;

   localparam logic [7:0] SYSEX_OPEN = 8'hF0;
   localparam logic [7:0] SYSEX_CLOSE = 8'hF7;
   localparam logic [7:0] STATUS_LOW = 8'h80;
   localparam logic [7:0] STATUS_HIGH = 8'hF6;
   localparam logic [4:0] REALTIME_TOP = 5'b11111;

   localparam logic [1:0] KIND_MSG = 2'd0;
   localparam logic [1:0] KIND_SYSEX = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      MODE_IGNORE,
      MODE_SHORT,
      MODE_SYSEX
   } mode_type;

   typedef enum logic [1:0] {
      OP_EMIT,
      OP_STORE,
      OP_DRAIN
   } cmd_op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_EMIT
   } back_state_type;

   // For OP_STORE the count field carries the buffer address and first_data the byte.
   typedef struct packed {
      cmd_op_type         op;
      logic [1:0]         kind;
      logic [7:0]         status;
      logic [7:0]         first_data;
      logic [7:0]         second_data;
      logic               truncated;
      logic [CNT_W-1:0]   count;
      logic [TIME_W-1:0]  stamp;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

// ===== rtl/msp_front.sv =====
module msp_front
   import msp_pkg::*;
#(
   parameter int SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              message_start,
   input  logic [TIME_W-1:0] arrival_time_ns,
   output logic              cmd_valid,
   output cmd_type           cmd
);

   localparam int CW = $clog2(SYSEX_DEPTH + 1);

   logic              in_excl_ff, in_excl_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in;
   mode_type          mode_ff, mode_in;
   logic [1:0]        pos_ff, pos_in;
   logic [7:0]        held_status_ff, held_status_in;
   logic [7:0]        held_d1_ff, held_d1_in;
   logic [TIME_W-1:0] held_time_ff, held_time_in;
   logic              do_open;

   always_comb begin
      in_excl_in = in_excl_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      mode_in = mode_ff;
      pos_in = pos_ff;
      held_status_in = held_status_ff;
      held_d1_in = held_d1_ff;
      held_time_in = held_time_ff;
      do_open = 1'b0;
      cmd_valid = 1'b0;
      cmd = '0;
      cmd.op = OP_EMIT;
      if (accept) begin
         if (message_start) begin
            held_time_in = arrival_time_ns;
            pos_in = 2'd0;
            if (data_byte[7:3] == REALTIME_TOP) begin
               mode_in = MODE_IGNORE;
               cmd_valid = 1'b1;
               cmd.kind = KIND_MSG;
               cmd.status = data_byte;
               cmd.stamp = arrival_time_ns;
            end else begin
               if (!in_excl_ff) begin
                  do_open = 1'b1;
               end else if (data_byte inside {[STATUS_LOW:STATUS_HIGH]}) begin
                  in_excl_in = 1'b0;
                  count_in = '0;
                  ovf_in = 1'b0;
                  do_open = 1'b1;
               end else begin
                  mode_in = MODE_SYSEX;
               end
               if (do_open) begin
                  if (data_byte == SYSEX_OPEN) begin
                     in_excl_in = 1'b1;
                     mode_in = MODE_SYSEX;
                  end else begin
                     held_status_in = data_byte;
                     mode_in = MODE_SHORT;
                     pos_in = 2'd1;
                  end
               end
            end
         end else begin
            case (mode_ff)
               MODE_SHORT: begin
                  if (pos_ff == 2'd1) begin
                     held_d1_in = data_byte;
                     pos_in = 2'd2;
                  end else begin
                     mode_in = MODE_IGNORE;
                     pos_in = 2'd0;
                     cmd_valid = 1'b1;
                     cmd.kind = KIND_MSG;
                     cmd.status = held_status_ff;
                     cmd.first_data = held_d1_ff;
                     cmd.second_data = data_byte;
                     cmd.stamp = held_time_ff;
                  end
               end
               MODE_SYSEX: begin
                  if (data_byte == SYSEX_CLOSE) begin
                     cmd_valid = 1'b1;
                     cmd.truncated = ovf_ff;
                     cmd.stamp = held_time_ff;
                     if (count_ff == '0) begin
                        cmd.op = OP_EMIT;
                        cmd.kind = KIND_EMPTY;
                     end else begin
                        cmd.op = OP_DRAIN;
                        cmd.count = CNT_W'(count_ff);
                     end
                     count_in = '0;
                     ovf_in = 1'b0;
                     in_excl_in = 1'b0;
                     mode_in = MODE_IGNORE;
                  end else if (count_ff < CW'(SYSEX_DEPTH)) begin
                     cmd_valid = 1'b1;
                     cmd.op = OP_STORE;
                     cmd.count = CNT_W'(count_ff);
                     cmd.first_data = data_byte;
                     count_in = count_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_excl_ff <= 1'b0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         mode_ff <= MODE_IGNORE;
         pos_ff <= 2'd0;
         held_status_ff <= '0;
         held_d1_ff <= '0;
         held_time_ff <= '0;
      end else begin
         in_excl_ff <= in_excl_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         held_status_ff <= held_status_in;
         held_d1_ff <= held_d1_in;
         held_time_ff <= held_time_in;
      end
   end

endmodule

// ===== rtl/msp_cmd_fifo.sv =====
module msp_cmd_fifo
   import msp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_type       push_cmd,
   input  logic          pop,
   output cmd_type       head_cmd,
   output fifo_stat_type stat
);

   localparam int PW = $clog2(CMD_FIFO_DEPTH);

   cmd_type         slot_ff [CMD_FIFO_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     fill_ff, fill_in;
   logic            do_push, do_pop;

   assign stat.full = (fill_ff == (PW + 1)'(CMD_FIFO_DEPTH));
   assign stat.empty = (fill_ff == '0);
   assign do_push = push && !stat.full;
   assign do_pop = pop && !stat.empty;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/msp_back.sv =====
module msp_back
   import msp_pkg::*;
#(
   parameter int SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           head_cmd,
   input  fifo_stat_type     stat,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_status,
   output logic [7:0]        rsp_first,
   output logic [7:0]        rsp_second,
   output logic              rsp_end,
   output logic              rsp_trunc,
   output logic [TIME_W-1:0] rsp_stamp
);

   localparam int CW = $clog2(SYSEX_DEPTH + 1);
   localparam int AW = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;

   back_state_type    state_ff, state_in;
   logic [7:0]        mem [SYSEX_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     cnt_ff;
   logic              trunc_ff;
   logic [TIME_W-1:0] stamp_ff;
   logic              valid_ff;
   logic [1:0]        kind_ff;
   logic [7:0]        status_ff, first_ff, second_ff;
   logic              end_ff, otrunc_ff;
   logic [TIME_W-1:0] ostamp_ff;
   logic              out_free, last_byte;
   logic              mem_we, load_single, load_byte, start_drain;

   assign out_free = !valid_ff || rsp_ready;
   assign last_byte = ((idx_ff + 1'b1) == cnt_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!stat.empty && head_cmd.op == OP_DRAIN) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) begin
               state_in = last_byte ? BK_IDLE : BK_READ;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop = 1'b0;
      mem_we = 1'b0;
      load_single = 1'b0;
      load_byte = 1'b0;
      start_drain = 1'b0;
      idx_in = idx_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!stat.empty) begin
               case (head_cmd.op)
                  OP_STORE: begin
                     pop = 1'b1;
                     mem_we = 1'b1;
                  end
                  OP_DRAIN: begin
                     pop = 1'b1;
                     start_drain = 1'b1;
                     idx_in = '0;
                  end
                  OP_EMIT: begin
                     if (out_free) begin
                        pop = 1'b1;
                        load_single = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               load_byte = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_single || load_byte) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (start_drain) begin
         cnt_ff <= CW'(head_cmd.count);
         trunc_ff <= head_cmd.truncated;
         stamp_ff <= head_cmd.stamp;
      end
      if (load_single) begin
         kind_ff <= head_cmd.kind;
         status_ff <= head_cmd.status;
         first_ff <= head_cmd.first_data;
         second_ff <= head_cmd.second_data;
         end_ff <= 1'b1;
         otrunc_ff <= head_cmd.truncated;
         ostamp_ff <= head_cmd.stamp;
      end else if (load_byte) begin
         kind_ff <= KIND_SYSEX;
         status_ff <= '0;
         first_ff <= rd_data_ff;
         second_ff <= '0;
         end_ff <= last_byte;
         otrunc_ff <= trunc_ff;
         ostamp_ff <= stamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[head_cmd.count[AW-1:0]] <= head_cmd.first_data;
      end
      rd_data_ff <= mem[idx_ff[AW-1:0]];
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_status = status_ff;
   assign rsp_first = first_ff;
   assign rsp_second = second_ff;
   assign rsp_end = end_ff;
   assign rsp_trunc = otrunc_ff;
   assign rsp_stamp = ostamp_ff;

endmodule

// ===== rtl/midi_message_sysex_parser.sv =====
// Channel  Direction  Contents
// req_     in         tdata: data_byte, arrival_time_ns; tuser: message_start
// rsp_     out        tdata: status, data 1, data 2, stamp; tuser: kind, truncated;
//                     tlast: run end
//
// The parser takes one beat per cycle while its four-entry command queue has room.
// Short, real-time and empty SysEx results are registered out once their command reaches the
// queue head and the output is free; each byte of a SysEx run goes through a read and an emit
// state via the buffer memory's registered read port, and input keeps flowing until the queue fills.
// Reset is synchronous and clears the parser state, the queue and the output valid.
// Either side may stall; the output register holds a result until it is taken.
module midi_message_sysex_parser
   import msp_pkg::*;
#(
   parameter int SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // data_byte [7:0], arrival_time_ns [47:8]
   input  logic        req_tuser,   // message_start [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // status [7:0], first [15:8], second [23:16], stamp [63:24]
   output logic [2:0]  rsp_tuser,   // kind [1:0], truncated [2]
   output logic        rsp_tlast
);

   logic              accept;
   logic              cmd_valid;
   cmd_type           cmd;
   cmd_type           head_cmd;
   fifo_stat_type     stat;
   logic              pop;
   logic [1:0]        o_kind;
   logic [7:0]        o_status, o_first, o_second;
   logic              o_end, o_trunc;
   logic [TIME_W-1:0] o_stamp;

   assign req_tready = !stat.full;
   assign accept = req_tvalid && req_tready;

   msp_front #(.SYSEX_DEPTH(SYSEX_DEPTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_tdata[7:0]),
      .message_start   (req_tuser),
      .arrival_time_ns (req_tdata[47:8]),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd)
   );

   msp_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_valid),
      .push_cmd (cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (stat)
   );

   msp_back #(.SYSEX_DEPTH(SYSEX_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .stat       (stat),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_kind   (o_kind),
      .rsp_status (o_status),
      .rsp_first  (o_first),
      .rsp_second (o_second),
      .rsp_end    (o_end),
      .rsp_trunc  (o_trunc),
      .rsp_stamp  (o_stamp)
   );

   assign rsp_tdata = {o_stamp, o_second, o_first, o_status};
   assign rsp_tuser = {o_trunc, o_kind};
   assign rsp_tlast = o_end;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> !stat.full)
      else $error("Command produced while the queue was full.");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("Command taken from an empty queue.");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (o_kind == KIND_MSG || o_kind == KIND_SYSEX || o_kind == KIND_EMPTY))
      else $error("Result beat carries an unknown kind.");

   a_sysex_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && o_kind != KIND_MSG) |-> (o_status == 8'd0 && o_second == 8'd0))
      else $error("SysEx result beat carries status or second data.");

endmodule
